@@ hw/rtl/jss_pkg.sv @@
// jss_pkg: shared constants, register codes and cell control type
// for the jacobi stencil sweep block; no dependencies
package jss_pkg;

   localparam int MAX_WIDTH_DEF   = 32;
   localparam int SAMPLE_BITS_DEF = 32;

   localparam int WIDTH_BITS     = 6;
   localparam int REG_BITS       = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WEST_BOUND = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EAST_BOUND = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_H_SQUARED  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_WIDTH = 2'd3;

   localparam logic signed [REG_BITS-1:0] WEST_BOUND_RESET = 32'sd0;
   localparam logic signed [REG_BITS-1:0] EAST_BOUND_RESET = 32'sd65536;
   localparam logic [REG_BITS-1:0]        H_SQUARED_RESET  = 32'd4559944;
   localparam logic [WIDTH_BITS-1:0]      GRID_WIDTH_RESET = 6'd32;
   localparam logic [WIDTH_BITS-1:0]      MIN_GRID_WIDTH   = 6'd2;

   typedef struct packed {
      logic                  write;
      logic                  rotate;
      logic                  flush;
      logic [WIDTH_BITS-1:0] write_col;
      logic [WIDTH_BITS-1:0] edge_col;
   } cell_ctrl_type;

endpackage

@@ hw/rtl/jss_cell.sv @@
// jss_cell: one grid column, holding three u rows and two b rows
// depends on jss_pkg; hands its row value to both neighbors
module jss_cell #(
   parameter int INDEX       = 0,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                          clock,
   input  jss_pkg::cell_ctrl_type        ctrl,
   input  logic signed [SAMPLE_BITS-1:0] west_bound,
   input  logic signed [SAMPLE_BITS-1:0] east_bound,
   input  logic signed [SAMPLE_BITS-1:0] u_in,
   input  logic signed [SAMPLE_BITS-1:0] b_in,
   input  logic signed [SAMPLE_BITS-1:0] west_share,
   input  logic signed [SAMPLE_BITS-1:0] east_share,
   output logic signed [SAMPLE_BITS-1:0] share_out,
   output logic signed [SAMPLE_BITS-1:0] tap_west,
   output logic signed [SAMPLE_BITS-1:0] tap_centre,
   output logic signed [SAMPLE_BITS-1:0] tap_east,
   output logic signed [SAMPLE_BITS-1:0] tap_south,
   output logic signed [SAMPLE_BITS-1:0] tap_source
);
   import jss_pkg::*;

   localparam logic [WIDTH_BITS-1:0] MY_COL = WIDTH_BITS'(INDEX);

   logic signed [SAMPLE_BITS-1:0] u0_ff, u1_ff, u2_ff, b0_ff, b1_ff;
   logic signed [SAMPLE_BITS-1:0] u2_in, b1_in;
   logic                          hit;

   assign hit   = ctrl.write && (ctrl.write_col == MY_COL);
   assign u2_in = hit ? u_in : u2_ff;
   assign b1_in = hit ? b_in : b1_ff;

   always_ff @(posedge clock) begin
      u2_ff <= u2_in;
      b1_ff <= b1_in;
      if (ctrl.rotate) begin
         u0_ff <= u1_ff;
         u1_ff <= u2_in;
         b0_ff <= b1_in;
      end
   end

   // flush reads the row being filled, normal work the row before it
   assign share_out  = ctrl.flush ? u2_ff : u1_ff;
   assign tap_centre = share_out;
   assign tap_west   = (INDEX == 0) ? west_bound : west_share;
   assign tap_east   = (ctrl.edge_col == MY_COL) ? east_bound : east_share;
   assign tap_south  = ctrl.flush ? u1_ff : u0_ff;
   assign tap_source = ctrl.flush ? b1_ff : b0_ff;

endmodule

@@ hw/rtl/jss_stencil_calc.sv @@
// jss_stencil_calc: product, neighbor sum, rounding and saturation
// depends on jss_pkg; owns the output register and the pipeline stall
module jss_stencil_calc #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic                           in_last,
   input  logic signed [SAMPLE_BITS-1:0]  west,
   input  logic signed [SAMPLE_BITS-1:0]  east,
   input  logic signed [SAMPLE_BITS-1:0]  south,
   input  logic signed [SAMPLE_BITS-1:0]  north,
   input  logic signed [SAMPLE_BITS-1:0]  source,
   input  logic [jss_pkg::REG_BITS-1:0]   h_squared,
   output logic                           advance,
   output logic                           out_valid,
   output logic                           out_last,
   output logic [SAMPLE_BITS-1:0]         out_value,
   input  logic                           out_ready
);
   import jss_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + REG_BITS + 1;
   localparam int SUM_BITS  = SAMPLE_BITS + 2;
   localparam int Q_BITS    = PROD_BITS - 30;
   localparam int T_BITS    = SAMPLE_BITS + 5;
   localparam int R_BITS    = T_BITS - 4;
   localparam logic signed [T_BITS-1:0] ROUND_BIAS = T_BITS'(8);

   logic                          s2_valid_ff, s2_last_ff;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic signed [REG_BITS:0]      h_sx;
   logic signed [Q_BITS-1:0]      q_val;
   logic signed [T_BITS-1:0]      t_val, sum_x4;
   logic signed [R_BITS-1:0]      r_val;
   logic [SAMPLE_BITS-1:0]        sat_val;
   logic                          out_valid_ff, out_last_ff;
   logic [SAMPLE_BITS-1:0]        out_value_ff;

   assign advance = !out_valid_ff || out_ready;

   assign h_sx    = $signed({1'b0, h_squared});
   assign prod_in = PROD_BITS'(source) * PROD_BITS'(h_sx);
   assign sum_in  = SUM_BITS'(west) + SUM_BITS'(east) + SUM_BITS'(south) + SUM_BITS'(north);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= in_valid;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff      <= prod_in;
         sum_ff       <= sum_in;
         s2_last_ff   <= in_last;
         out_value_ff <= sat_val;
         out_last_ff  <= s2_last_ff;
      end
   end

   // q in Q.18, then round to nearest with ties upward
   assign q_val  = $signed(prod_ff[PROD_BITS-1:30]);
   assign sum_x4 = T_BITS'(sum_ff) <<< 2;
   assign t_val  = T_BITS'(q_val) + sum_x4 + ROUND_BIAS;
   assign r_val  = R_BITS'(t_val >>> 4);

   always_comb begin
      if (r_val[R_BITS-1] != r_val[R_BITS-2]) begin
         sat_val = {r_val[R_BITS-1], {(SAMPLE_BITS-1){~r_val[R_BITS-1]}}};
      end else begin
         sat_val = r_val[SAMPLE_BITS-1:0];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_last  = out_last_ff;
   assign out_value = out_value_ff;

endmodule

@@ hw/rtl/jacobi_stencil_sweep.sv @@
// jacobi_stencil_sweep: top level, column cells, control and config registers
// depends on jss_pkg, jss_cell and jss_stencil_calc
//
// One Jacobi sweep of the five-point Poisson stencil over a raster stream of
// (u, b) cells. A row of column cells holds the last rows; one cell a cycle is
// taken while no output stall or final row flush holds the input and, from the
// second row on, the result for the same column of the row above passes through
// the issue, product and output registers. A beat with tlast ends the frame: the
// block then stops taking input while the single stencil pipeline emits the
// final row (up to the grid width), one result per cycle when the output does
// not stall. Output stalls hold the whole pipeline; no clearing pass is run
// after reset.
module jacobi_stencil_sweep #(
   parameter int MAX_WIDTH   = jss_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = jss_pkg::SAMPLE_BITS_DEF,
   localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
   localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [IN_DATA_BITS-1:0]             req_tdata,   // u_value, b_value
   input  logic                                req_tlast,   // frame_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [OUT_DATA_BITS-1:0]            rsp_tdata,   // u_new
   output logic                                rsp_tlast,   // last_cell
   input  logic                                csr_wr_en,
   input  logic [jss_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [jss_pkg::REG_BITS-1:0]        csr_wdata
);
   import jss_pkg::*;

   localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [WIDTH_BITS-1:0] MAX_W = WIDTH_BITS'(MAX_WIDTH);
   localparam logic [1:0] ROW_FIRST  = 2'd0;
   localparam logic [1:0] ROW_SECOND = 2'd1;
   localparam logic [1:0] ROW_LATER  = 2'd2;

   // configuration
   logic signed [SAMPLE_BITS-1:0] west_bound_ff, east_bound_ff;
   logic [REG_BITS-1:0]           h_squared_ff;
   logic [WIDTH_BITS-1:0]         grid_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         west_bound_ff <= SAMPLE_BITS'(WEST_BOUND_RESET);
         east_bound_ff <= SAMPLE_BITS'(EAST_BOUND_RESET);
         h_squared_ff  <= H_SQUARED_RESET;
         grid_width_ff <= GRID_WIDTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_WEST_BOUND: west_bound_ff <= SAMPLE_BITS'($signed(csr_wdata));
            REG_EAST_BOUND: east_bound_ff <= SAMPLE_BITS'($signed(csr_wdata));
            REG_H_SQUARED:  h_squared_ff  <= csr_wdata;
            REG_GRID_WIDTH: grid_width_ff <= csr_wdata[WIDTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // control
   logic [WIDTH_BITS-1:0] column_count_ff, column_count_in;
   logic [1:0]            row_count_ff, row_count_in;
   logic                  flush_active_ff, flush_active_in;
   logic [WIDTH_BITS-1:0] flush_k_ff, flush_k_in;
   logic [WIDTH_BITS-1:0] flush_end_ff, flush_end_in;
   logic                  flush_row0_ff, flush_row0_in;
   logic [WIDTH_BITS-1:0] width_eff, last_col, col, sel;
   logic                  advance, accept, end_of_row, flush_done;
   logic signed [SAMPLE_BITS-1:0] req_u, req_b;

   assign req_u = req_tdata[SAMPLE_BITS-1:0];
   assign req_b = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

   always_comb begin
      if (grid_width_ff < MIN_GRID_WIDTH) begin
         width_eff = MIN_GRID_WIDTH;
      end else if (grid_width_ff > MAX_W) begin
         width_eff = MAX_W;
      end else begin
         width_eff = grid_width_ff;
      end
   end

   assign last_col   = width_eff - WIDTH_BITS'(1);
   assign col        = (column_count_ff < width_eff) ? column_count_ff : last_col;
   assign end_of_row = (col == last_col);
   assign req_tready = advance && !flush_active_ff;
   assign accept     = req_tvalid && req_tready;
   assign flush_done = (flush_k_ff == flush_end_ff);
   assign sel        = flush_active_ff ? flush_k_ff : col;

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      flush_active_in = flush_active_ff;
      flush_k_in      = flush_k_ff;
      flush_end_in    = flush_end_ff;
      flush_row0_in   = flush_row0_ff;
      if (flush_active_ff && advance) begin
         flush_k_in = flush_k_ff + WIDTH_BITS'(1);
         if (flush_done) begin
            flush_active_in = 1'b0;
         end
      end
      if (accept) begin
         if (req_tlast) begin
            column_count_in = '0;
            row_count_in    = ROW_FIRST;
            flush_active_in = 1'b1;
            flush_k_in      = '0;
            flush_end_in    = col;
            flush_row0_in   = (row_count_ff == ROW_FIRST);
         end else if (end_of_row) begin
            column_count_in = '0;
            row_count_in    = (row_count_ff == ROW_FIRST) ? ROW_SECOND : ROW_LATER;
         end else begin
            column_count_in = col + WIDTH_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= ROW_FIRST;
         flush_active_ff <= 1'b0;
         flush_k_ff      <= '0;
         flush_end_ff    <= '0;
         flush_row0_ff   <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         flush_active_ff <= flush_active_in;
         flush_k_ff      <= flush_k_in;
         flush_end_ff    <= flush_end_in;
         flush_row0_ff   <= flush_row0_in;
      end
   end

   // column cells
   cell_ctrl_type cell_ctrl;
   logic signed [SAMPLE_BITS-1:0] share    [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] t_west   [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] t_centre [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] t_east   [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] t_south  [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] t_source [MAX_WIDTH];

   assign cell_ctrl.write     = accept;
   assign cell_ctrl.rotate    = accept && !req_tlast && end_of_row;
   assign cell_ctrl.flush     = flush_active_ff;
   assign cell_ctrl.write_col = col;
   assign cell_ctrl.edge_col  = flush_active_ff ? flush_end_ff : last_col;

   for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] west_share, east_share;
      if (k == 0) begin : g_west_edge
         assign west_share = west_bound_ff;
      end else begin : g_west_link
         assign west_share = share[k-1];
      end
      if (k == MAX_WIDTH - 1) begin : g_east_edge
         assign east_share = east_bound_ff;
      end else begin : g_east_link
         assign east_share = share[k+1];
      end
      jss_cell #(
         .INDEX       (k),
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .west_bound (west_bound_ff),
         .east_bound (east_bound_ff),
         .u_in       (req_u),
         .b_in       (req_b),
         .west_share (west_share),
         .east_share (east_share),
         .share_out  (share[k]),
         .tap_west   (t_west[k]),
         .tap_centre (t_centre[k]),
         .tap_east   (t_east[k]),
         .tap_south  (t_south[k]),
         .tap_source (t_source[k])
      );
   end

   // issue stage
   logic                          s1_valid_ff, s1_last_ff, issue_valid, south_is_centre;
   logic signed [SAMPLE_BITS-1:0] s1_west_ff, s1_east_ff, s1_south_ff, s1_north_ff;
   logic signed [SAMPLE_BITS-1:0] s1_source_ff, pick_centre;
   logic [COL_BITS-1:0]           pick;

   assign pick            = sel[COL_BITS-1:0];
   assign pick_centre     = t_centre[pick];
   assign issue_valid     = (accept && (row_count_ff != ROW_FIRST)) || flush_active_ff;
   assign south_is_centre = flush_active_ff ? flush_row0_ff : (row_count_ff == ROW_SECOND);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= issue_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_last_ff   <= flush_active_ff && flush_done;
         s1_west_ff   <= t_west[pick];
         s1_east_ff   <= t_east[pick];
         s1_south_ff  <= south_is_centre ? pick_centre : t_south[pick];
         s1_north_ff  <= flush_active_ff ? pick_centre : req_u;
         s1_source_ff <= t_source[pick];
      end
   end

   logic [SAMPLE_BITS-1:0] u_new;

   jss_stencil_calc #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_last   (s1_last_ff),
      .west      (s1_west_ff),
      .east      (s1_east_ff),
      .south     (s1_south_ff),
      .north     (s1_north_ff),
      .source    (s1_source_ff),
      .h_squared (h_squared_ff),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_last  (rsp_tlast),
      .out_value (u_new),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = OUT_DATA_BITS'(u_new);

   // checks
   a_flush_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> flush_active_ff)
      else $error("frame end beat did not start the final row flush");

   a_flush_bound: assert property (@(posedge clock) disable iff (reset)
      flush_active_ff |-> (flush_k_ff <= flush_end_ff))
      else $error("flush column ran past the final column");

   a_column_range: assert property (@(posedge clock) disable iff (reset)
      column_count_ff < MAX_W)
      else $error("column count beyond the cell row");

   a_last_after_flush: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff) |-> !flush_active_ff)
      else $error("last result issued while the flush is still running");

endmodule

@@ tb/testbench.sv @@
// testbench for jacobi_stencil_sweep: directed stimulus table, then random frames
// checked beat by beat against a five-point stencil predictor; needs jss_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
   import jss_pkg::*;

   localparam int MAX_W = MAX_WIDTH_DEF;
   localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SAT_LO = -SAT_HI - 1;
   localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SMIN = 32'h8000_0000;
   localparam int DIRECTED_ROWS = 39;
   localparam int RANDOM_CELLS = 100;
   localparam int TALL_ROWS = 8;

   typedef enum logic {ROW_CELL, ROW_CSR} row_kind_type;

   // csr rows: word_a is the register data, word_b the register index
   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  word_a;
      logic [31:0]  word_b;
      logic         frame_end;
      logic         has_typed;
      logic [31:0]  typed_u_new;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] u_new;
      logic        last_cell;
   } cell_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // u_value, b_value
   logic        req_tlast = 1'b0;  // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // u_new
   logic        rsp_tlast;         // last_cell
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_WEST_BOUND;
   logic [REG_BITS-1:0]       csr_wdata = '0;

   // predictor state
   logic signed [31:0]   west_fix;
   logic signed [31:0]   east_fix;
   logic [31:0]          h_sq;
   logic [WIDTH_BITS-1:0] width_reg;
   logic signed [31:0]   u_rows [0:2][0:MAX_W-1];
   logic signed [31:0]   b_rows [0:1][0:MAX_W-1];
   int                   col_pos;
   int                   row_pos;

   cell_result_type pending_cells [$];
   cell_result_type head_cell;
   int           error_count = 0;
   int           burst_left = 0;
   logic [8:0]   stall_tick = '0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // reset settings, single cell frame
      '{ROW_CELL, 32'h0, 32'h0, 1'b1, 1'b1, 32'h0000_4000},
      '{ROW_CSR, 32'h0000_0001, 32'(REG_GRID_WIDTH), 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, SMAX, 32'(REG_WEST_BOUND), 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, SMAX, 32'(REG_EAST_BOUND), 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, 32'hFFFF_FFFF, 32'(REG_H_SQUARED), 1'b0, 1'b0, 32'h0},
      // positive saturation
      '{ROW_CELL, SMAX, SMAX, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, SMAX, SMAX, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, SMAX, SMAX, 1'b0, 1'b1, SMAX},
      '{ROW_CELL, SMAX, SMAX, 1'b1, 1'b0, 32'h0},
      '{ROW_CSR, SMIN, 32'(REG_WEST_BOUND), 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, SMIN, 32'(REG_EAST_BOUND), 1'b0, 1'b0, 32'h0},
      // negative saturation
      '{ROW_CELL, SMIN, SMIN, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, SMIN, SMIN, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, SMIN, SMIN, 1'b0, 1'b1, SMIN},
      '{ROW_CELL, SMIN, SMIN, 1'b1, 1'b0, 32'h0},
      // width above the maximum, frame ends inside the first row
      '{ROW_CSR, 32'hFFFF_FFFF, 32'(REG_GRID_WIDTH), 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, 32'h0001_8000, 32'(REG_WEST_BOUND), 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, 32'hFFFE_0000, 32'(REG_EAST_BOUND), 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, H_SQUARED_RESET, 32'(REG_H_SQUARED), 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'h0003_0000, 32'hFFFF_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'hFFFD_8000, 32'h0040_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'h0000_0001, 32'h8000_0001, 1'b1, 1'b0, 32'h0},
      // frame ends inside the second row
      '{ROW_CSR, 32'h0000_0003, 32'(REG_GRID_WIDTH), 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'h0001_0000, 32'h0002_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'h0002_0000, 32'hFFFF_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'h0004_0000, 32'h0000_8000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'hFFFF_0000, 32'h0010_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'h0000_4000, SMAX, 1'b1, 1'b0, 32'h0},
      // width shrinks while a row is open
      '{ROW_CSR, 32'h0000_0004, 32'(REG_GRID_WIDTH), 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'h0002_0000, 32'h0002_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'h0003_0000, 32'h0003_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'h0004_0000, 32'h0004_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'hFFFF_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'hFFFE_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'hFFFD_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, 32'h0000_0002, 32'(REG_GRID_WIDTH), 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'h0010_0000, 32'h0100_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CELL, 32'hFFF0_0000, 32'hFF00_0000, 1'b1, 1'b0, 32'h0}
   };

   jacobi_stencil_sweep i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int effective_width();
      if (width_reg < MIN_GRID_WIDTH) return MIN_GRID_WIDTH;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
   endfunction

   function automatic logic [31:0] stencil_value(input logic signed [31:0] w_nb, e_nb,
                                                 s_nb, n_nb, b_val);
      longint prod;
      longint acc;
      longint h_wide;
      h_wide = h_sq;
      prod = longint'(b_val) * h_wide;
      acc = (prod >>> 30) + ((longint'(w_nb) + longint'(e_nb) + longint'(s_nb)
            + longint'(n_nb)) <<< 2) + 8;
      acc = acc >>> 4;
      if (acc > SAT_HI) acc = SAT_HI;
      else if (acc < SAT_LO) acc = SAT_LO;
      return acc[31:0];
   endfunction

   function automatic void predict_sweep_cell(input logic [31:0] u_val, b_val,
                                              input logic frame_end);
      int w;
      int col;
      int k;
      logic signed [31:0] centre;
      logic signed [31:0] w_nb;
      logic signed [31:0] e_nb;
      logic signed [31:0] s_nb;
      w = effective_width();
      col = (col_pos < w) ? col_pos : w - 1;
      u_rows[2][col] = u_val;
      b_rows[1][col] = b_val;
      // row above, same column
      if (row_pos >= 1) begin
         centre = u_rows[1][col];
         w_nb = (col > 0) ? u_rows[1][col-1] : west_fix;
         e_nb = (col < w - 1) ? u_rows[1][col+1] : east_fix;
         s_nb = (row_pos == 1) ? centre : u_rows[0][col];
         pending_cells.push_back('{stencil_value(w_nb, e_nb, s_nb, u_rows[2][col],
                                                 b_rows[0][col]), 1'b0});
      end
      if (frame_end) begin
         // flush the open row, current column is its east edge
         for (k = 0; k <= col; k++) begin
            centre = u_rows[2][k];
            w_nb = (k > 0) ? u_rows[2][k-1] : west_fix;
            e_nb = (k < col) ? u_rows[2][k+1] : east_fix;
            s_nb = (row_pos == 0) ? centre : u_rows[1][k];
            pending_cells.push_back('{stencil_value(w_nb, e_nb, s_nb, centre, b_rows[1][k]),
                                      k == col});
         end
         col_pos = 0;
         row_pos = 0;
      end else if (col == w - 1) begin
         for (k = 0; k < MAX_W; k++) begin
            u_rows[0][k] = u_rows[1][k];
            u_rows[1][k] = u_rows[2][k];
            b_rows[0][k] = b_rows[1][k];
         end
         col_pos = 0;
         if (row_pos < 63) row_pos++;
      end else begin
         col_pos = col + 1;
      end
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                          input logic [31:0] data);
      case (idx)
         REG_WEST_BOUND: west_fix = data;
         REG_EAST_BOUND: east_fix = data;
         REG_H_SQUARED:  h_sq = data;
         REG_GRID_WIDTH: width_reg = data[WIDTH_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] random_sample();
      case ($urandom_range(7))
         0: return SMAX;
         1: return SMIN;
         2: return 32'h0;
         3, 4: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] random_h_sq();
      case ($urandom_range(4))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return H_SQUARED_RESET;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] random_width();
      case ($urandom_range(9))
         0: return $urandom_range(1);
         1: return $urandom_range(31, 7);
         2: return $urandom_range(63, 32);
         default: return $urandom_range(6, 2);
      endcase
   endfunction

   task automatic send_cell(input logic [31:0] u_val, b_val, input logic frame_end,
                            input logic has_typed, input logic [31:0] typed_u_new);
      int first;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b_val, u_val};
      req_tlast <= frame_end;
      do @(posedge clock); while (!req_tready);
      first = pending_cells.size();
      predict_sweep_cell(u_val, b_val, frame_end);
      if (has_typed) pending_cells[first].u_new = typed_u_new;
      burst_left--;
   endtask

   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [31:0] data);
      wait_until_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      apply_register(idx, data);
   endtask

   // result side: stall pattern and checking
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[8:7])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(3) != 0);
         2'd2: rsp_tready <= (stall_tick[1:0] == 2'd0);
         default: rsp_tready <= ($urandom_range(4) == 0);
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cells.size() == 0) begin
            $error("unexpected result beat: u_new %h last_cell %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            head_cell = pending_cells.pop_front();
            if (rsp_tdata !== head_cell.u_new) begin
               $error("u_new: expected %h, actual %h", head_cell.u_new, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== head_cell.last_cell) begin
               $error("last_cell: expected %b, actual %b", head_cell.last_cell, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int i;
      int r;
      int c;
      int w;
      int rows;
      int total;
      int sent;
      west_fix = WEST_BOUND_RESET;
      east_fix = EAST_BOUND_RESET;
      h_sq = H_SQUARED_RESET;
      width_reg = GRID_WIDTH_RESET;
      col_pos = 0;
      row_pos = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_register(directed_rows[i].word_b[CSR_INDEX_BITS-1:0],
                           directed_rows[i].word_a);
         else
            send_cell(directed_rows[i].word_a, directed_rows[i].word_b,
                      directed_rows[i].frame_end, directed_rows[i].has_typed,
                      directed_rows[i].typed_u_new);
      end

      // tall frame of narrow rows
      write_register(REG_WEST_BOUND, random_sample());
      write_register(REG_EAST_BOUND, random_sample());
      write_register(REG_H_SQUARED, random_h_sq());
      write_register(REG_GRID_WIDTH, 32'd2);
      for (r = 0; r < TALL_ROWS; r++)
         for (c = 0; c < 2; c++)
            send_cell(random_sample(), random_sample(), r == TALL_ROWS - 1 && c == 1,
                      1'b0, 32'h0);

      sent = 0;
      while (sent < RANDOM_CELLS) begin
         write_register(REG_WEST_BOUND, random_sample());
         write_register(REG_EAST_BOUND, random_sample());
         write_register(REG_H_SQUARED, random_h_sq());
         write_register(REG_GRID_WIDTH, random_width());
         repeat ($urandom_range(3, 1)) begin
            w = effective_width();
            rows = (w > 8) ? $urandom_range(2, 1) : $urandom_range(5, 1);
            total = rows * w;
            // some frames end early, often inside a row
            if ($urandom_range(5) == 0) total = $urandom_range(total, 1);
            for (i = 0; i < total; i++) begin
               send_cell(random_sample(), random_sample(), i == total - 1, 1'b0, 32'h0);
               sent++;
            end
         end
      end

      wait_until_idle();
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/jss_pkg.sv
hw/rtl/jss_cell.sv
hw/rtl/jss_stencil_calc.sv
hw/rtl/jacobi_stencil_sweep.sv
tb/testbench.sv
